// File: design/sos_pkg.sv
// sos_pkg: shared widths, configuration codes, controller/datapath command and
// status structs, and the elaboration-time cosine table for the sweep segmenter.
// No dependencies.
`timescale 1ns / 1ps

package sos_pkg;

    // Field widths
    localparam int ANGLE_W  = 8;
    localparam int DIST_W   = 10;
    localparam int COUNT_W  = 7;
    localparam int WIDTH_W  = 11;
    localparam int CENTER_W = 8;
    localparam int CFG_W    = 11;

    localparam int MAX_OBJECTS   = 16;
    localparam int COS_FRAC_BITS = 15;
    localparam int COS_WORK_BITS = 28;
    localparam int COS_TERMS     = 40;

    // cos needs one integer bit plus sign
    localparam int COS_W       = COS_FRAC_BITS + 2;
    localparam int COS_ENTRIES = 2 ** ANGLE_W;
    localparam int SQ_W        = 2 * DIST_W;          // a*a, b*b, a*b
    localparam int SUM_W       = SQ_W + 1;            // a*a + b*b
    localparam int PROD_W      = SQ_W + 1 + COS_W;    // signed a*b*c
    localparam int Q_W         = PROD_W + 2;          // squared width in Q.F
    localparam int RAD_W       = 2 * DIST_W + 2;      // floor of squared width
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int STEP_W      = $clog2(ROOT_W);
    localparam int COUNT_MAX   = 2 ** COUNT_W - 1;

    // Reset values of the configuration registers
    localparam logic [DIST_W-1:0]  ENTER_RESET      = DIST_W'(20);
    localparam logic [DIST_W-1:0]  EXIT_IR_RESET    = DIST_W'(20);
    localparam logic [DIST_W-1:0]  EXIT_SONAR_RESET = DIST_W'(10);
    localparam logic [WIDTH_W-1:0] CEILING_RESET    = WIDTH_W'(500);

    typedef enum logic [1:0] {
        CFG_ENTER      = 2'd0,
        CFG_EXIT_IR    = 2'd1,
        CFG_EXIT_SONAR = 2'd2,
        CFG_SIZE_CEIL  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic load_sample;
        logic clear_sweep;
        logic open_object;
        logic start_close;
        logic load_cos;
        logic load_prod;
        logic load_rad;
        logic root_step;
        logic close_object;
        logic load_summary;
    } sos_cmd_t;

    typedef struct packed {
        logic scan_start;
        logic scan_last;
        logic can_open;
        logic can_close;
        logic root_done;
        logic summary_free;
    } sos_stat_t;

    typedef logic signed [COS_W-1:0] cos_table_t [COS_ENTRIES];

    // Angle in degrees scaled by 157 over 9000 gives radians with pi as 3.14
    localparam longint unsigned CosMul = 157;
    localparam longint unsigned CosDen = 9000;

    // Floor quotient by shift and subtract; only used while building COS_TABLE.
    function automatic longint unsigned div_floor(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Taylor series in Q28, rounded half up to Q.COS_FRAC_BITS.
    // Only evaluated at elaboration to build COS_TABLE.
    function automatic cos_table_t build_cos_table();
        cos_table_t tab;
        longint unsigned m;
        longint unsigned t;
        longint unsigned den;
        longint sum;
        longint biased;
        for (int d = 0; d < COS_ENTRIES; d++)
        begin
            m   = longint'(d) * CosMul;
            t   = 64'd1 << COS_WORK_BITS;
            sum = longint'(t);
            for (int k = 1; k <= COS_TERMS; k++)
            begin
                den = CosDen * longint'(2 * k - 1) * longint'(2 * k);
                t   = div_floor(t * m, CosDen);
                t   = div_floor(t * m, den);
                if ((k & 1) == 1)
                    sum = sum - longint'(t);
                else
                    sum = sum + longint'(t);
            end
            biased = sum + (64'sd1 <<< (COS_WORK_BITS + 2));
            biased = (biased + (64'sd1 <<< (COS_WORK_BITS - COS_FRAC_BITS - 1)))
                     >>> (COS_WORK_BITS - COS_FRAC_BITS);
            tab[d] = COS_W'(biased - (64'sd1 <<< (COS_FRAC_BITS + 2)));
        end
        return tab;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

// File: design/sos_sample_if.sv
// sos_sample_if: valid/ready channel carrying one sweep sample.
// Depends on sos_pkg for field widths.
`timescale 1ns / 1ps

interface sos_sample_if;
    logic                       valid;
    logic                       ready;
    logic [sos_pkg::ANGLE_W-1:0] angle_deg;
    logic [sos_pkg::DIST_W-1:0]  ir_cm;
    logic [sos_pkg::DIST_W-1:0]  sonar_cm;
    logic                       scan_start;
    logic                       scan_last;

    modport source (output valid, angle_deg, ir_cm, sonar_cm, scan_start, scan_last,
                    input ready);
    modport sink   (input valid, angle_deg, ir_cm, sonar_cm, scan_start, scan_last,
                    output ready);
endinterface

// File: design/sos_summary_if.sv
// sos_summary_if: valid/ready channel carrying one sweep summary.
// Depends on sos_pkg for field widths.
`timescale 1ns / 1ps

interface sos_summary_if;
    logic                         valid;
    logic                         ready;
    logic [sos_pkg::COUNT_W-1:0]  object_count;
    logic [sos_pkg::COUNT_W-1:0]  smallest_index;
    logic [sos_pkg::CENTER_W-1:0] smallest_center;
    logic [sos_pkg::WIDTH_W-1:0]  smallest_width;
    logic                         overflow;

    modport source (output valid, object_count, smallest_index, smallest_center,
                    smallest_width, overflow, input ready);
    modport sink   (input valid, object_count, smallest_index, smallest_center,
                    smallest_width, overflow, output ready);
endinterface

// File: design/sweep_object_segmenter_top.sv
// Sweep object segmenter. One sample at a time: the input is not ready again until
// the sample is done. A sample that opens, ignores or starts a sweep is only decided;
// a sample that closes an object also runs products, cosine lookup, an 11-step
// square root and the update. A summary sample then loads the output register, after
// any wait for the previous summary to be taken. Asynchronous active-low reset restores
// the default limits and clears the sweep; no clearing pass is needed.
`timescale 1ns / 1ps

module sweep_object_segmenter_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  sos_pkg::cfg_index_t       cfg_index,
    input  logic [sos_pkg::CFG_W-1:0] cfg_data,
    sos_sample_if.sink                sample,
    sos_summary_if.source             summary
);

    sos_pkg::sos_cmd_t  cmd;
    sos_pkg::sos_stat_t stat;

    sos_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    sos_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .angle_deg  (sample.angle_deg),
        .ir_cm      (sample.ir_cm),
        .sonar_cm   (sample.sonar_cm),
        .scan_start (sample.scan_start),
        .scan_last  (sample.scan_last),
        .cmd        (cmd),
        .stat       (stat),
        .summary    (summary)
    );

endmodule

// File: design/sos_datapath.sv
// sos_datapath: config registers, sweep state, width arithmetic (products,
// cosine lookup, digit-by-digit square root) and the summary output register.
// Depends on sos_pkg and sos_summary_if.
`timescale 1ns / 1ps

module sos_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  sos_pkg::cfg_index_t          cfg_index,
    input  logic [sos_pkg::CFG_W-1:0]    cfg_data,
    input  logic [sos_pkg::ANGLE_W-1:0]  angle_deg,
    input  logic [sos_pkg::DIST_W-1:0]   ir_cm,
    input  logic [sos_pkg::DIST_W-1:0]   sonar_cm,
    input  logic                         scan_start,
    input  logic                         scan_last,
    input  sos_pkg::sos_cmd_t            cmd,
    output sos_pkg::sos_stat_t           stat,
    sos_summary_if.source                summary
);

    // Configuration
    logic [sos_pkg::DIST_W-1:0]  enter_limit_reg;
    logic [sos_pkg::DIST_W-1:0]  exit_ir_limit_reg;
    logic [sos_pkg::DIST_W-1:0]  exit_sonar_limit_reg;
    logic [sos_pkg::WIDTH_W-1:0] size_ceiling_reg;

    // Captured sample
    logic [sos_pkg::ANGLE_W-1:0] angle_reg;
    logic [sos_pkg::DIST_W-1:0]  ir_reg;
    logic [sos_pkg::DIST_W-1:0]  sonar_reg;
    logic                        start_reg;
    logic                        last_reg;

    // Sweep state
    logic                         in_object_reg;
    logic [sos_pkg::ANGLE_W-1:0]  open_angle_reg;
    logic [sos_pkg::DIST_W-1:0]   open_distance_reg;
    logic [sos_pkg::COUNT_W-1:0]  closed_count_reg;
    logic [sos_pkg::WIDTH_W-1:0]  best_width_reg;
    logic [sos_pkg::COUNT_W-1:0]  best_index_reg;
    logic [sos_pkg::CENTER_W-1:0] best_center_reg;
    logic                         overflow_reg;

    // Width arithmetic
    logic [sos_pkg::ANGLE_W-1:0]       d_reg;
    logic [sos_pkg::SQ_W-1:0]          aa_reg;
    logic [sos_pkg::SQ_W-1:0]          bb_reg;
    logic [sos_pkg::SQ_W-1:0]          ab_reg;
    logic [sos_pkg::SUM_W-1:0]         sum_reg;
    logic signed [sos_pkg::COS_W-1:0]  cos_reg;
    logic signed [sos_pkg::PROD_W-1:0] prod_reg;
    logic [sos_pkg::RAD_W-1:0]         rad_reg;
    logic [sos_pkg::REM_W-1:0]         rem_reg;
    logic [sos_pkg::ROOT_W-1:0]        root_reg;
    logic [sos_pkg::STEP_W-1:0]        step_reg;

    // Summary output register
    logic                         out_valid_reg;
    logic [sos_pkg::COUNT_W-1:0]  out_count_reg;
    logic [sos_pkg::COUNT_W-1:0]  out_index_reg;
    logic [sos_pkg::CENTER_W-1:0] out_center_reg;
    logic [sos_pkg::WIDTH_W-1:0]  out_width_reg;
    logic                         out_overflow_reg;

    logic signed [sos_pkg::Q_W-1:0]  q_next;
    logic [sos_pkg::RAD_W-1:0]       rad_next;
    logic [sos_pkg::REM_W+1:0]       rem_shift;
    logic [sos_pkg::REM_W+1:0]       trial;
    logic                            fits;
    logic [sos_pkg::ANGLE_W-1:0]     d_next;
    logic [sos_pkg::ANGLE_W:0]       center_sum;
    logic [sos_pkg::WIDTH_W-1:0]     width_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_limit_reg      <= sos_pkg::ENTER_RESET;
            exit_ir_limit_reg    <= sos_pkg::EXIT_IR_RESET;
            exit_sonar_limit_reg <= sos_pkg::EXIT_SONAR_RESET;
            size_ceiling_reg     <= sos_pkg::CEILING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sos_pkg::CFG_ENTER:      enter_limit_reg      <= cfg_data[sos_pkg::DIST_W-1:0];
                sos_pkg::CFG_EXIT_IR:    exit_ir_limit_reg    <= cfg_data[sos_pkg::DIST_W-1:0];
                sos_pkg::CFG_EXIT_SONAR: exit_sonar_limit_reg <= cfg_data[sos_pkg::DIST_W-1:0];
                sos_pkg::CFG_SIZE_CEIL:  size_ceiling_reg     <= cfg_data[sos_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            angle_reg <= angle_deg;
            ir_reg    <= ir_cm;
            sonar_reg <= sonar_cm;
            start_reg <= scan_start;
            last_reg  <= scan_last;
        end
    end

    assign stat.scan_start   = start_reg;
    assign stat.scan_last    = last_reg;
    assign stat.can_open     = !in_object_reg && (ir_reg < enter_limit_reg)
                               && (sonar_reg < enter_limit_reg);
    assign stat.can_close    = in_object_reg && (ir_reg > exit_ir_limit_reg)
                               && (sonar_reg > exit_sonar_limit_reg);
    assign stat.root_done    = (step_reg == sos_pkg::STEP_W'(sos_pkg::ROOT_W - 1));
    assign stat.summary_free = !out_valid_reg || summary.ready;

    assign d_next = (angle_reg >= open_angle_reg) ? (angle_reg - open_angle_reg)
                                                  : (open_angle_reg - angle_reg);

    // Squared width: ((a^2 + b^2) << F) - 2ab*cos, clamped at zero, then >> F
    assign q_next = ($signed(sos_pkg::Q_W'(sum_reg)) <<< sos_pkg::COS_FRAC_BITS)
                    - (sos_pkg::Q_W'(prod_reg) <<< 1);
    assign rad_next = q_next[sos_pkg::Q_W-1] ? '0
                      : q_next[sos_pkg::COS_FRAC_BITS +: sos_pkg::RAD_W];

    // One root bit per step
    assign rem_shift = {rem_reg, rad_reg[sos_pkg::RAD_W-1 -: 2]};
    assign trial     = (sos_pkg::REM_W + 2)'({root_reg, 2'b01});
    assign fits      = (rem_shift >= trial);

    assign center_sum = {1'b0, open_angle_reg} + {1'b0, angle_reg};
    assign width_now  = sos_pkg::WIDTH_W'(root_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start_close)
        begin
            d_reg  <= d_next;
            aa_reg <= sos_pkg::SQ_W'(open_distance_reg) * sos_pkg::SQ_W'(open_distance_reg);
            bb_reg <= sos_pkg::SQ_W'(ir_reg) * sos_pkg::SQ_W'(ir_reg);
            ab_reg <= sos_pkg::SQ_W'(open_distance_reg) * sos_pkg::SQ_W'(ir_reg);
        end
        if (cmd.load_cos)
        begin
            cos_reg <= sos_pkg::COS_TABLE[d_reg];
            sum_reg <= {1'b0, aa_reg} + {1'b0, bb_reg};
        end
        if (cmd.load_prod)
            prod_reg <= $signed(sos_pkg::PROD_W'({1'b0, ab_reg}))
                        * sos_pkg::PROD_W'(cos_reg);
        if (cmd.load_rad)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            step_reg <= step_reg + 1'b1;
            if (fits)
            begin
                rem_reg  <= sos_pkg::REM_W'(rem_shift - trial);
                root_reg <= {root_reg[sos_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sos_pkg::REM_W'(rem_shift);
                root_reg <= {root_reg[sos_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_object_reg     <= 1'b0;
            open_angle_reg    <= '0;
            open_distance_reg <= '0;
            closed_count_reg  <= '0;
            best_width_reg    <= sos_pkg::CEILING_RESET;
            best_index_reg    <= '0;
            best_center_reg   <= '0;
            overflow_reg      <= 1'b0;
        end
        else if (cmd.clear_sweep)
        begin
            in_object_reg     <= 1'b0;
            open_angle_reg    <= '0;
            open_distance_reg <= '0;
            closed_count_reg  <= '0;
            best_width_reg    <= size_ceiling_reg;
            best_index_reg    <= '0;
            best_center_reg   <= '0;
            overflow_reg      <= 1'b0;
        end
        else if (cmd.open_object)
        begin
            in_object_reg     <= 1'b1;
            open_angle_reg    <= angle_reg;
            open_distance_reg <= ir_reg;
        end
        else if (cmd.close_object)
        begin
            in_object_reg <= 1'b0;
            // ties keep the earlier object
            if (width_now < best_width_reg)
            begin
                best_width_reg  <= width_now;
                best_index_reg  <= closed_count_reg;
                best_center_reg <= center_sum[sos_pkg::ANGLE_W:1];
            end
            if (closed_count_reg >= sos_pkg::COUNT_W'(sos_pkg::MAX_OBJECTS))
                overflow_reg <= 1'b1;
            if (closed_count_reg != sos_pkg::COUNT_W'(sos_pkg::COUNT_MAX))
                closed_count_reg <= closed_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_summary)
            out_valid_reg <= 1'b1;
        else if (summary.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_summary)
        begin
            out_count_reg    <= closed_count_reg;
            out_index_reg    <= best_index_reg;
            out_center_reg   <= best_center_reg;
            out_width_reg    <= best_width_reg;
            out_overflow_reg <= overflow_reg;
        end
    end

    assign summary.valid           = out_valid_reg;
    assign summary.object_count    = out_count_reg;
    assign summary.smallest_index  = out_index_reg;
    assign summary.smallest_center = out_center_reg;
    assign summary.smallest_width  = out_width_reg;
    assign summary.overflow        = out_overflow_reg;

endmodule

// File: design/sos_ctrl.sv
// sos_ctrl: sequencer for one sample at a time; steps the datapath through
// decision, width evaluation, square root and summary load.
// Depends on sos_pkg.
`timescale 1ns / 1ps

module sos_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  sos_pkg::sos_stat_t stat,
    output sos_pkg::sos_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_COS,
        S_PROD,
        S_RAD,
        S_ROOT,
        S_UPDATE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign after_item   = stat.scan_last ? S_EMIT : S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.scan_start)
                begin
                    cmd.clear_sweep = 1'b1;
                    state_next      = after_item;
                end
                else if (stat.can_open)
                begin
                    cmd.open_object = 1'b1;
                    state_next      = after_item;
                end
                else if (stat.can_close)
                begin
                    cmd.start_close = 1'b1;
                    state_next      = S_COS;
                end
                else
                    state_next = after_item;
            end
            S_COS:
            begin
                cmd.load_cos = 1'b1;
                state_next   = S_PROD;
            end
            S_PROD:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_RAD;
            end
            S_RAD:
            begin
                cmd.load_rad = 1'b1;
                state_next   = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.close_object = 1'b1;
                state_next       = after_item;
            end
            S_EMIT:
            begin
                if (stat.summary_free)
                begin
                    cmd.load_summary = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: tb/sv/sweep_object_checker.sv
// sweep_object_checker: watches the sample, summary and register ports of the sweep
// object segmenter, predicts each sweep summary and compares it with the block's.
// Depends on sos_pkg, sos_sample_if and sos_summary_if.
`timescale 1ns / 1ps

module sweep_object_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  sos_pkg::cfg_index_t       cfg_index,
    input  logic [sos_pkg::CFG_W-1:0] cfg_data,
    sos_sample_if                     sample,
    sos_summary_if                    summary,
    output int                        errors,
    output int                        outstanding
);
    import sos_pkg::*;

    // degrees to radians with pi taken as 3.14
    localparam longint unsigned RAD_NUM = 157;
    localparam longint unsigned RAD_DEN = 9000;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  index;
        logic [CENTER_W-1:0] center;
        logic [WIDTH_W-1:0]  width;
        logic                overflow;
    } sweep_summary_t;

    sweep_summary_t expected_summaries[$];
    longint         cos_by_angle [COS_ENTRIES];

    logic [DIST_W-1:0]  enter_lim;
    logic [DIST_W-1:0]  exit_ir_lim;
    logic [DIST_W-1:0]  exit_sonar_lim;
    logic [WIDTH_W-1:0] ceiling;

    logic               in_obj;
    logic [ANGLE_W-1:0] open_ang;
    logic [DIST_W-1:0]  open_ir;
    int unsigned        closed;
    logic [WIDTH_W-1:0] best_w;
    int unsigned        best_idx;
    logic [ANGLE_W-1:0] best_ctr;
    logic               ovf;

    // Taylor series in Q28, rounded half up (floor of biased value) to Q15
    function automatic longint cosine_q15(int unsigned deg);
        longint unsigned m;
        longint unsigned t;
        longint          acc;
        m   = longint'(deg) * RAD_NUM;
        t   = 64'd1 << COS_WORK_BITS;
        acc = longint'(t);
        for (int k = 1; k <= COS_TERMS; k++)
        begin
            t = t * m / RAD_DEN;
            t = t * m / (RAD_DEN * longint'(2 * k - 1) * longint'(2 * k));
            if (k % 2 == 1)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        return (acc + (64'sd1 <<< (COS_WORK_BITS - COS_FRAC_BITS - 1)))
               >>> (COS_WORK_BITS - COS_FRAC_BITS);
    endfunction

    // law of cosines, floor at every step
    function automatic logic [WIDTH_W-1:0] chord_width(input logic [DIST_W-1:0]  a_cm,
                                                       input logic [DIST_W-1:0]  b_cm,
                                                       input logic [ANGLE_W-1:0] span);
        longint          a;
        longint          b;
        longint          q;
        longint unsigned v;
        longint unsigned root;
        longint unsigned trial;
        a = longint'(a_cm);
        b = longint'(b_cm);
        q = ((a * a + b * b) <<< COS_FRAC_BITS) - 2 * a * b * cos_by_angle[span];
        if (q < 0)
            q = 0;
        v    = q >> COS_FRAC_BITS;
        root = 0;
        for (int bitpos = 12; bitpos >= 0; bitpos--)
        begin
            trial = root | (64'd1 << bitpos);
            if (trial * trial <= v)
                root = trial;
        end
        if (root > 2047)
            root = 2047;
        return WIDTH_W'(root);
    endfunction

    task automatic begin_sweep();
        in_obj   = 1'b0;
        open_ang = '0;
        open_ir  = '0;
        closed   = 0;
        best_w   = ceiling;
        best_idx = 0;
        best_ctr = '0;
        ovf      = 1'b0;
    endtask

    task automatic track_sample(input logic [ANGLE_W-1:0] ang,
                                input logic [DIST_W-1:0]  ir,
                                input logic [DIST_W-1:0]  son,
                                input logic               st,
                                input logic               ls);
        logic [ANGLE_W-1:0] span;
        logic [WIDTH_W-1:0] w;
        sweep_summary_t     s;
        if (st)
            begin_sweep();
        else if (!in_obj && ir < enter_lim && son < enter_lim)
        begin
            in_obj   = 1'b1;
            open_ang = ang;
            open_ir  = ir;
        end
        else if (in_obj && ir > exit_ir_lim && son > exit_sonar_lim)
        begin
            span   = (ang >= open_ang) ? ang - open_ang : open_ang - ang;
            w      = chord_width(open_ir, ir, span);
            in_obj = 1'b0;
            // strictly narrower only; a tie keeps the earlier object
            if (w < best_w)
            begin
                best_w   = w;
                best_idx = closed;
                best_ctr = ANGLE_W'(({1'b0, open_ang} + {1'b0, ang}) >> 1);
            end
            if (closed >= MAX_OBJECTS)
                ovf = 1'b1;
            if (closed < COUNT_MAX)
                closed++;
        end
        if (ls)
        begin
            s.count    = COUNT_W'(closed);
            s.index    = COUNT_W'(best_idx);
            s.center   = best_ctr;
            s.width    = best_w;
            s.overflow = ovf;
            expected_summaries.push_back(s);
        end
    endtask

    task automatic check_summary();
        sweep_summary_t got;
        sweep_summary_t want;
        got.count    = summary.object_count;
        got.index    = summary.smallest_index;
        got.center   = summary.smallest_center;
        got.width    = summary.smallest_width;
        got.overflow = summary.overflow;
        if (expected_summaries.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: summary with none pending: count=%0d index=%0d",
                         $time, got.count, got.index,
                         " center=%0d width=%0d ovf=%0b",
                         got.center, got.width, got.overflow);
            errors++;
        end
        else
        begin
            want = expected_summaries.pop_front();
            if (got !== want)
            begin
                if (errors < 10)
                    $display("%0t: summary mismatch: exp count=%0d index=%0d center=%0d",
                             $time, want.count, want.index, want.center,
                             " width=%0d ovf=%0b,", want.width, want.overflow,
                             " got count=%0d index=%0d center=%0d width=%0d ovf=%0b",
                             got.count, got.index, got.center, got.width,
                             got.overflow);
                errors++;
            end
        end
    endtask

    initial
    begin
        for (int d = 0; d < COS_ENTRIES; d++)
            cos_by_angle[d] = cosine_q15(d);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_lim      = ENTER_RESET;
            exit_ir_lim    = EXIT_IR_RESET;
            exit_sonar_lim = EXIT_SONAR_RESET;
            ceiling        = CEILING_RESET;
            begin_sweep();
            expected_summaries.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENTER:      enter_lim      = cfg_data[DIST_W-1:0];
                    CFG_EXIT_IR:    exit_ir_lim    = cfg_data[DIST_W-1:0];
                    CFG_EXIT_SONAR: exit_sonar_lim = cfg_data[DIST_W-1:0];
                    CFG_SIZE_CEIL:  ceiling        = cfg_data[WIDTH_W-1:0];
                    default:        ;
                endcase
            end
            if (summary.valid && summary.ready)
                check_summary();
            if (sample.valid && sample.ready)
                track_sample(sample.angle_deg, sample.ir_cm, sample.sonar_cm,
                             sample.scan_start, sample.scan_last);
            outstanding = expected_summaries.size();
        end
    end

endmodule

// File: tb/sv/tb_sweep_object_segmenter_top.sv
// tb_sweep_object_segmenter_top: drives sweeps of samples and limit settings into the
// segmenter, stalls the summary side, and reports the verdict from sweep_object_checker.
// Depends on sos_pkg, both channel interfaces, the checker and the block.
`timescale 1ns / 1ps

module tb_sweep_object_segmenter_top;
    import sos_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DIST_MAX      = 2 ** DIST_W - 1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    cfg_index_t        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                errors;
    int                outstanding;
    int unsigned       cycles = 0;
    bit                idle_allowed;
    bit                gaps_on;
    bit                stalls_on;
    int                stall_left;
    int                phase_items;

    // stimulus-side copies of the limits, used to shape the distances
    logic [DIST_W-1:0] enter_lim;
    logic [DIST_W-1:0] exit_ir_lim;
    logic [DIST_W-1:0] exit_sonar_lim;

    sos_sample_if  smp_ch ();
    sos_summary_if sum_ch ();

    sweep_object_segmenter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp_ch),
        .summary   (sum_ch)
    );

    sweep_object_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (smp_ch),
        .summary     (sum_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("[sweep_object_segmenter_top] ERROR");
            $finish;
        end
    end

    // summary side: ready is dropped in random bursts of stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            sum_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (stalls_on && $urandom_range(0, 11) == 0)
        begin
            sum_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end
        else
            sum_ch.ready <= 1'b1;
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_sample(input logic [ANGLE_W-1:0] ang,
                               input logic [DIST_W-1:0]  ir,
                               input logic [DIST_W-1:0]  son,
                               input logic               st,
                               input logic               ls);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        smp_ch.valid      <= 1'b1;
        smp_ch.angle_deg  <= ang;
        smp_ch.ir_cm      <= ir;
        smp_ch.sonar_cm   <= son;
        smp_ch.scan_start <= st;
        smp_ch.scan_last  <= ls;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        @(negedge clk);
        phase_items++;
    endtask

    // drain all summaries, then give a closing object time to finish
    task automatic settle();
        smp_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_limits(input int unsigned enter, input int unsigned x_ir,
                              input int unsigned x_sonar, input int unsigned ceil_w);
        settle();
        write_reg(CFG_ENTER, enter);
        write_reg(CFG_EXIT_IR, x_ir);
        write_reg(CFG_EXIT_SONAR, x_sonar);
        write_reg(CFG_SIZE_CEIL, ceil_w);
        enter_lim      = DIST_W'(enter);
        exit_ir_lim    = DIST_W'(x_ir);
        exit_sonar_lim = DIST_W'(x_sonar);
    endtask

    function automatic logic [DIST_W-1:0] near_cm();
        if (enter_lim == 0)
            return DIST_W'($urandom);
        return DIST_W'($urandom_range(0, int'(enter_lim) - 1));
    endfunction

    function automatic logic [DIST_W-1:0] far_cm(input logic [DIST_W-1:0] lim);
        if (lim == DIST_MAX)
            return DIST_W'($urandom);
        return DIST_W'($urandom_range(int'(lim) + 1, DIST_MAX));
    endfunction

    // one sweep: runs of near and far samples with a slowly moving angle
    task automatic run_sweep(input int len, input bit with_start, input int flip_pct,
                             input int noise_pct);
        logic [ANGLE_W-1:0] ang;
        logic [DIST_W-1:0]  ir;
        logic [DIST_W-1:0]  son;
        logic               st;
        logic               ls;
        bit                 near_run;
        ang      = ANGLE_W'($urandom);
        near_run = 1'b0;
        if (with_start)
            send_sample(ANGLE_W'($urandom), DIST_W'($urandom), DIST_W'($urandom),
                        1'b1, 1'b0);
        for (int i = 0; i < len; i++)
        begin
            st = 1'b0;
            ls = (i == len - 1) || ($urandom_range(0, 99) < 2);
            if ($urandom_range(0, 99) < flip_pct)
                near_run = !near_run;
            ang = ang + ANGLE_W'($urandom_range(0, 4));
            if ($urandom_range(0, 99) < noise_pct)
            begin
                ang = ANGLE_W'($urandom);
                ir  = DIST_W'($urandom);
                son = DIST_W'($urandom);
                st  = ($urandom_range(0, 3) == 0);
            end
            else if (near_run)
            begin
                ir  = near_cm();
                son = near_cm();
            end
            else
            begin
                ir  = far_cm(exit_ir_lim);
                son = far_cm(exit_sonar_lim);
            end
            send_sample(ang, ir, son, st, ls);
        end
    endtask

    task automatic run_phase(input int budget, input int flip_pct);
        int len;
        phase_items = 0;
        while (phase_items < budget)
        begin
            if (idle_allowed)
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(4, 30);
            run_sweep(len, $urandom_range(0, 99) < 85, flip_pct, 8);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_ENTER;
        cfg_data          = '0;
        smp_ch.valid      = 1'b0;
        smp_ch.angle_deg  = '0;
        smp_ch.ir_cm      = '0;
        smp_ch.sonar_cm   = '0;
        smp_ch.scan_start = 1'b0;
        smp_ch.scan_last  = 1'b0;
        sum_ch.ready      = 1'b0;
        idle_allowed      = 1'b1;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        stall_left        = 0;
        enter_lim         = ENTER_RESET;
        exit_ir_lim       = EXIT_IR_RESET;
        exit_sonar_lim    = EXIT_SONAR_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed items with the reset limits (enter 20, exit 20/10, ceiling 500)
        send_sample(8'd255, 10'd1023, 10'd1023, 1'b1, 1'b1); // start and last: empty sweep
        send_sample(8'd0, 10'd0, 10'd0, 1'b1, 1'b0);
        send_sample(8'd0, 10'd0, 10'd0, 1'b0, 1'b0);         // opens at zero distance
        send_sample(8'd255, 10'd1023, 10'd1023, 1'b0, 1'b0); // closes across full span
        send_sample(8'd10, 10'd19, 10'd19, 1'b0, 1'b0);
        send_sample(8'd11, 10'd5, 10'd5, 1'b0, 1'b0);        // already open
        send_sample(8'd12, 10'd20, 10'd11, 1'b0, 1'b0);      // ir on the exit limit
        send_sample(8'd12, 10'd21, 10'd11, 1'b0, 1'b0);
        send_sample(8'd12, 10'd19, 10'd19, 1'b0, 1'b0);
        send_sample(8'd14, 10'd21, 10'd11, 1'b0, 1'b0);      // same width again
        send_sample(8'd20, 10'd20, 10'd0, 1'b0, 1'b0);       // ir on the enter limit
        send_sample(8'd30, 10'd0, 10'd19, 1'b0, 1'b0);
        send_sample(8'd30, 10'd1023, 10'd1023, 1'b0, 1'b0);  // zero span
        send_sample(8'd200, 10'd5, 10'd5, 1'b0, 1'b0);
        send_sample(8'd100, 10'd25, 10'd900, 1'b0, 1'b1);    // closes on the last item
        send_sample(8'd50, 10'd3, 10'd3, 1'b0, 1'b1);        // left open at summary
        settle();
        write_reg(CFG_SIZE_CEIL, 0);                         // no effect until next start
        send_sample(8'd60, 10'd600, 10'd600, 1'b0, 1'b0);
        send_sample(8'd61, 10'd1, 10'd1, 1'b0, 1'b1);
        send_sample(8'd0, 10'd0, 10'd0, 1'b1, 1'b0);
        send_sample(8'd5, 10'd2, 10'd2, 1'b0, 1'b0);
        send_sample(8'd6, 10'd100, 10'd100, 1'b0, 1'b1);

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: set_limits(1023, 0, 0, 2047);
                1: set_limits(0, 1023, 1023, 0);
                2: set_limits(300, 300, 200, 1000);
                4: set_limits($urandom_range(1, 1023), 1023, $urandom_range(0, 1023),
                              $urandom_range(0, 2047));
                5: set_limits(64, 500, 100, 2047);
                default: set_limits($urandom_range(1, 400), $urandom_range(0, 800),
                                    $urandom_range(0, 800), $urandom_range(0, 2047));
            endcase
            if (p == 9)
            begin
                idle_allowed = 1'b0;
                gaps_on      = 1'b0;
                stalls_on    = 1'b0;
            end
            if (p == 1 || p == 4)
                run_phase(40, 40);
            else if (p == 5)
            begin
                // one item per flip: well over 127 objects, saturating the count
                run_sweep(300, 1'b1, 100, 0);
                run_phase(50, 40);
            end
            else
                run_phase(130, 35);
        end

        settle();
        if (errors == 0 && outstanding == 0)
            $display("[sweep_object_segmenter_top] OK");
        else
            $display("[sweep_object_segmenter_top] ERROR");
        $finish;
    end

endmodule
